// ===== src/gpu_command_packet_parser_defines.svh =====
`ifndef GPU_COMMAND_PACKET_PARSER_DEFINES_SVH
`define GPU_COMMAND_PACKET_PARSER_DEFINES_SVH

// check that a condition implies another in the same cycle
`define GCPP_ASSERT_IMPLY(label, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error("gcpp check failed");

// check that a condition implies another in the next cycle
`define GCPP_ASSERT_NEXT(label, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error("gcpp check failed");

`endif

// ===== src/gcpp_pkg.sv =====
package gcpp_pkg;

    localparam int unsigned WORD_W   = 32;
    localparam int unsigned ADDR_W   = 17;
    localparam int unsigned LEFT_W   = 15;
    localparam int unsigned CNT_W    = 14;
    localparam int unsigned OPC_W    = 8;
    localparam int unsigned KIND_W   = 3;
    localparam int unsigned CIDX_W   = 8;
    localparam int unsigned TDATA_W  = 128;
    localparam int unsigned TUSER_W  = 5;

    localparam logic [ADDR_W-1:0] IB_BASE_RESET = 17'h00700;
    localparam logic [ADDR_W-1:0] IB_SIZE_RESET = 17'h00704;

    localparam logic [CIDX_W-1:0] REG_IB_BASE = 8'd0;
    localparam logic [CIDX_W-1:0] REG_IB_SIZE = 8'd1;

    localparam logic [1:0] PKT_TYPE0 = 2'd0;
    localparam logic [1:0] PKT_TYPE2 = 2'd2;
    localparam logic [1:0] PKT_TYPE3 = 2'd3;

    typedef enum logic [KIND_W-1:0] {
        KIND_TYPE0_HDR = 3'd0,
        KIND_TYPE2_HDR = 3'd1,
        KIND_TYPE3_HDR = 3'd2,
        KIND_REG_WRITE = 3'd3,
        KIND_PAYLOAD   = 3'd4,
        KIND_BAD_TYPE  = 3'd5
    } kind_t;

    typedef enum logic [1:0] {
        PH_HEADER = 2'd0,
        PH_TYPE0  = 2'd1,
        PH_TYPE3  = 2'd2
    } phase_t;

    typedef struct packed {
        phase_t              phase;
        logic [LEFT_W-1:0]   words_left;
        logic [ADDR_W-1:0]   next_reg;
        logic                fixed_reg;
        logic [OPC_W-1:0]    cur_opcode;
        logic [WORD_W-1:0]   ib_base_latch;
    } state_t;

    typedef struct packed {
        logic [ADDR_W-1:0]   ib_base_addr;
        logic [ADDR_W-1:0]   ib_size_addr;
    } cfg_t;

    typedef struct packed {
        kind_t               kind;
        logic [ADDR_W-1:0]   reg_addr;
        logic [WORD_W-1:0]   word_out;
        logic [OPC_W-1:0]    opcode;
        logic                ib_valid;
        logic [WORD_W-1:0]   ib_address;
        logic [WORD_W-1:0]   ib_length;
        logic                truncated;
    } result_t;

endpackage

// ===== src/gcpp_decode.sv =====
module gcpp_decode
(
    input  gcpp_pkg::state_t                  state,
    input  gcpp_pkg::cfg_t                    cfg,
    input  logic [gcpp_pkg::WORD_W-1:0]       word,
    input  logic                              stream_end,
    output gcpp_pkg::state_t                  state_next,
    output gcpp_pkg::result_t                 result
);

    always_comb
    begin
        logic [1:0]                      pkt_type;
        logic [gcpp_pkg::CNT_W-1:0]      cnt;
        logic [gcpp_pkg::LEFT_W-1:0]     left_dec;
        logic [gcpp_pkg::WORD_W-1:0]     latch_tmp;

        pkt_type   = word[31:30];
        cnt        = word[29:16];
        left_dec   = state.words_left - gcpp_pkg::LEFT_W'(1);
        latch_tmp  = state.ib_base_latch;
        state_next = state;

        result            = '0;
        result.kind       = gcpp_pkg::KIND_TYPE0_HDR;
        result.word_out   = word;

        case (state.phase)
            gcpp_pkg::PH_TYPE0:
            begin
                result.kind     = gcpp_pkg::KIND_REG_WRITE;
                result.reg_addr = state.next_reg;
                if (state.next_reg == cfg.ib_base_addr)
                begin
                    latch_tmp = word;
                end
                state_next.ib_base_latch = latch_tmp;
                if (state.next_reg == cfg.ib_size_addr)
                begin
                    result.ib_valid          = 1'b1;
                    result.ib_address        = latch_tmp;
                    result.ib_length         = word;
                    state_next.ib_base_latch = '0;
                end
                if (!state.fixed_reg)
                begin
                    state_next.next_reg = state.next_reg + gcpp_pkg::ADDR_W'(4);
                end
                state_next.words_left = left_dec;
                if (left_dec == '0)
                begin
                    state_next.phase = gcpp_pkg::PH_HEADER;
                end
            end
            gcpp_pkg::PH_TYPE3:
            begin
                result.kind           = gcpp_pkg::KIND_PAYLOAD;
                result.opcode         = state.cur_opcode;
                state_next.words_left = left_dec;
                if (left_dec == '0)
                begin
                    state_next.phase = gcpp_pkg::PH_HEADER;
                end
            end
            default:
            begin
                state_next.phase = gcpp_pkg::PH_HEADER;
                case (pkt_type)
                    gcpp_pkg::PKT_TYPE0:
                    begin
                        result.kind           = gcpp_pkg::KIND_TYPE0_HDR;
                        state_next.fixed_reg  = word[15];
                        state_next.next_reg   = {2'b00, word[12:0], 2'b00};
                        state_next.words_left = {1'b0, cnt} + gcpp_pkg::LEFT_W'(1);
                        state_next.phase      = gcpp_pkg::PH_TYPE0;
                    end
                    gcpp_pkg::PKT_TYPE2:
                    begin
                        result.kind = gcpp_pkg::KIND_TYPE2_HDR;
                    end
                    gcpp_pkg::PKT_TYPE3:
                    begin
                        result.kind           = gcpp_pkg::KIND_TYPE3_HDR;
                        state_next.cur_opcode = word[15:8];
                        result.opcode         = word[15:8];
                        state_next.words_left = {1'b0, cnt} + gcpp_pkg::LEFT_W'(1);
                        state_next.phase      = gcpp_pkg::PH_TYPE3;
                    end
                    default:
                    begin
                        result.kind = gcpp_pkg::KIND_BAD_TYPE;
                    end
                endcase
            end
        endcase

        if (stream_end && (state_next.phase != gcpp_pkg::PH_HEADER))
        begin
            result.truncated      = 1'b1;
            state_next.phase      = gcpp_pkg::PH_HEADER;
            state_next.words_left = '0;
        end
    end

endmodule

// ===== src/gpu_command_packet_parser.sv =====
// Command packet parser: splits a stream of 32-bit command words into
// packet headers, register writes and opaque payload, one result per word.
// Channels:
//   s_*   : command words in; tdata = word, tlast marks the end of a stream span.
//   m_*   : one result beat per command word (fields listed at the port).
//   cfg_* : register writes; index 0 sets the IB base register address,
//           index 1 the IB size register address. cfg_ready is always high.
// Throughput: one word per cycle while m_tready is high, set by the single decode
// stage between the input register and the result register.
// A word is held in the input register, and its result in the result register.
// A write to the IB size register gives ib_valid with the latched base.
// A stream end inside a packet sets truncated and drops the rest of it.
// Reset: the parser waits for a header, the IB latch is cleared and the
// register addresses return to 0x700 and 0x704.
// Stall: a held result keeps its beat stable; an empty input register still takes
// one more word, then s_tready drops until m_tready returns.
`include "gpu_command_packet_parser_defines.svh"

module gpu_command_packet_parser
(
    input  logic                                 clk,
    input  logic                                 rst_n,

    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [gcpp_pkg::WORD_W-1:0]          s_tdata,   // word[31:0]
    input  logic                                 s_tlast,

    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // reg_addr[16:0], word_out[48:17], opcode[56:49], ib_address[88:57],
    // ib_length[120:89], zero fill[127:121]
    output logic [gcpp_pkg::TDATA_W-1:0]         m_tdata,
    // kind[2:0], ib_valid[3], truncated[4]
    output logic [gcpp_pkg::TUSER_W-1:0]         m_tuser,

    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [gcpp_pkg::CIDX_W-1:0]          cfg_index,
    input  logic [gcpp_pkg::ADDR_W-1:0]          cfg_data
);

    logic                          in_valid_reg;
    logic [gcpp_pkg::WORD_W-1:0]   in_word_reg;
    logic                          in_end_reg;
    logic                          out_valid_reg;
    gcpp_pkg::result_t             out_reg;
    gcpp_pkg::state_t              state_reg;
    gcpp_pkg::state_t              state_next;
    gcpp_pkg::cfg_t                cfg_reg;
    gcpp_pkg::result_t             result;
    logic                          out_free;
    logic                          advance;

    assign out_free  = !out_valid_reg || m_tready;
    assign advance   = in_valid_reg && out_free;
    assign s_tready  = !in_valid_reg || out_free;
    assign cfg_ready = 1'b1;

    gcpp_decode u_decode
    (
        .state      (state_reg),
        .cfg        (cfg_reg),
        .word       (in_word_reg),
        .stream_end (in_end_reg),
        .state_next (state_next),
        .result     (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg           <= 1'b0;
            out_valid_reg          <= 1'b0;
            state_reg.phase        <= gcpp_pkg::PH_HEADER;
            state_reg.words_left   <= '0;
            state_reg.next_reg     <= '0;
            state_reg.fixed_reg    <= 1'b0;
            state_reg.cur_opcode   <= '0;
            state_reg.ib_base_latch <= '0;
            cfg_reg.ib_base_addr   <= gcpp_pkg::IB_BASE_RESET;
            cfg_reg.ib_size_addr   <= gcpp_pkg::IB_SIZE_RESET;
        end
        else
        begin
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (out_free)
            begin
                out_valid_reg <= in_valid_reg;
            end
            if (advance)
            begin
                state_reg <= state_next;
            end
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == gcpp_pkg::REG_IB_BASE)
                begin
                    cfg_reg.ib_base_addr <= cfg_data;
                end
                else if (cfg_index == gcpp_pkg::REG_IB_SIZE)
                begin
                    cfg_reg.ib_size_addr <= cfg_data;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_word_reg <= s_tdata;
            in_end_reg  <= s_tlast;
        end
        if (advance)
        begin
            out_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, out_reg.ib_length, out_reg.ib_address, out_reg.opcode,
                       out_reg.word_out, out_reg.reg_addr};
    assign m_tuser  = {out_reg.truncated, out_reg.ib_valid, out_reg.kind};

    `GCPP_ASSERT_IMPLY(a_ib_on_reg_write, m_tvalid && out_reg.ib_valid,
        out_reg.kind == gcpp_pkg::KIND_REG_WRITE)
    `GCPP_ASSERT_IMPLY(a_trunc_in_packet, m_tvalid && out_reg.truncated,
        out_reg.kind != gcpp_pkg::KIND_TYPE2_HDR && out_reg.kind != gcpp_pkg::KIND_BAD_TYPE)
    `GCPP_ASSERT_NEXT(a_stage_hold, in_valid_reg && !out_free, in_valid_reg)
    `GCPP_ASSERT_NEXT(a_trunc_to_header, advance && result.truncated,
        state_reg.phase == gcpp_pkg::PH_HEADER && state_reg.words_left == '0)

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;

    localparam int unsigned PHASE_WORDS = 215;
    localparam int unsigned NUM_PHASES  = 6;
    localparam int unsigned HOLD_CYCLES = 300;
    localparam int unsigned QUIET_LIMIT = 3000;
    localparam int unsigned SHOW_LIMIT  = 10;

    localparam logic [1:0] PKT_TYPE1 = 2'd1;

    localparam logic [gcpp_pkg::ADDR_W-1:0] BASE_PLAN [NUM_PHASES] =
        '{gcpp_pkg::IB_BASE_RESET, 17'h00000, 17'h1ffff, 17'h00100, 17'h07ffc, 17'h00040};
    localparam logic [gcpp_pkg::ADDR_W-1:0] SIZE_PLAN [NUM_PHASES] =
        '{gcpp_pkg::IB_SIZE_RESET, 17'h00004, 17'h00000, 17'h00100, 17'h07ff8, 17'h00044};

    typedef struct {
        logic [gcpp_pkg::WORD_W-1:0] word;
        logic                        last;
        logic                        typed;
        gcpp_pkg::result_t           res;
    } cmd_row_t;

    logic                              clk       = 1'b0;
    logic                              rst_n     = 1'b0;
    logic                              s_tvalid  = 1'b0;
    logic                              s_tready;
    logic [gcpp_pkg::WORD_W-1:0]       s_tdata   = '0;
    logic                              s_tlast   = 1'b0;
    logic                              m_tvalid;
    logic                              m_tready  = 1'b0;
    logic [gcpp_pkg::TDATA_W-1:0]      m_tdata;
    logic [gcpp_pkg::TUSER_W-1:0]      m_tuser;
    logic                              cfg_valid = 1'b0;
    logic                              cfg_ready;
    logic [gcpp_pkg::CIDX_W-1:0]       cfg_index = gcpp_pkg::REG_IB_BASE;
    logic [gcpp_pkg::ADDR_W-1:0]       cfg_data  = '0;

    gcpp_pkg::phase_t                  parse_phase  = gcpp_pkg::PH_HEADER;
    logic [gcpp_pkg::LEFT_W-1:0]       words_owed   = '0;
    logic [gcpp_pkg::ADDR_W-1:0]       next_reg     = '0;
    logic                              hold_reg     = 1'b0;
    logic [gcpp_pkg::OPC_W-1:0]        opcode_cur   = '0;
    logic [gcpp_pkg::WORD_W-1:0]       ib_base_held = '0;
    logic [gcpp_pkg::ADDR_W-1:0]       ib_base_addr = gcpp_pkg::IB_BASE_RESET;
    logic [gcpp_pkg::ADDR_W-1:0]       ib_size_addr = gcpp_pkg::IB_SIZE_RESET;

    gcpp_pkg::result_t    beats_due [$];
    cmd_row_t             dir_rows [$];
    int unsigned          words_sent   = 0;
    int unsigned          mismatches   = 0;
    int unsigned          quiet_cycles = 0;
    int unsigned          tx_idle_pct  = 24;
    int unsigned          rx_idle_pct  = 72;
    logic                 hold_rx      = 1'b0;

    gpu_command_packet_parser i_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic gcpp_pkg::result_t decode_word(input logic [gcpp_pkg::WORD_W-1:0] w,
                                                      input logic last);
        gcpp_pkg::result_t r;
        r = '0;
        r.word_out = w;
        if (parse_phase == gcpp_pkg::PH_TYPE0 || parse_phase == gcpp_pkg::PH_TYPE3)
        begin
            if (parse_phase == gcpp_pkg::PH_TYPE0)
            begin
                r.kind     = gcpp_pkg::KIND_REG_WRITE;
                r.reg_addr = next_reg;
                if (next_reg == ib_base_addr)
                    ib_base_held = w;
                if (next_reg == ib_size_addr)
                begin
                    r.ib_valid   = 1'b1;
                    r.ib_address = ib_base_held;
                    r.ib_length  = w;
                    ib_base_held = '0;
                end
                if (!hold_reg)
                    next_reg = next_reg + 17'd4;
            end
            else
            begin
                r.kind   = gcpp_pkg::KIND_PAYLOAD;
                r.opcode = opcode_cur;
            end
            words_owed = words_owed - 15'd1;
            if (words_owed == '0)
                parse_phase = gcpp_pkg::PH_HEADER;
        end
        else
        begin
            parse_phase = gcpp_pkg::PH_HEADER;
            case (w[31:30])
                gcpp_pkg::PKT_TYPE0:
                begin
                    r.kind      = gcpp_pkg::KIND_TYPE0_HDR;
                    hold_reg    = w[15];
                    next_reg    = {2'b00, w[12:0], 2'b00};
                    words_owed  = {1'b0, w[29:16]} + 15'd1;
                    parse_phase = gcpp_pkg::PH_TYPE0;
                end
                gcpp_pkg::PKT_TYPE2:
                    r.kind = gcpp_pkg::KIND_TYPE2_HDR;
                gcpp_pkg::PKT_TYPE3:
                begin
                    r.kind      = gcpp_pkg::KIND_TYPE3_HDR;
                    opcode_cur  = w[15:8];
                    r.opcode    = w[15:8];
                    words_owed  = {1'b0, w[29:16]} + 15'd1;
                    parse_phase = gcpp_pkg::PH_TYPE3;
                end
                default:
                    r.kind = gcpp_pkg::KIND_BAD_TYPE;
            endcase
        end
        if (last && parse_phase != gcpp_pkg::PH_HEADER)
        begin
            r.truncated = 1'b1;
            parse_phase = gcpp_pkg::PH_HEADER;
            words_owed  = '0;
        end
        return r;
    endfunction

    function automatic string show_beat(input gcpp_pkg::result_t r);
        return $sformatf("kind=%0d addr=%h word=%h opc=%h ibv=%b iba=%h ibl=%h trunc=%b",
                         r.kind, r.reg_addr, r.word_out, r.opcode, r.ib_valid,
                         r.ib_address, r.ib_length, r.truncated);
    endfunction

    task automatic add_row(input logic [gcpp_pkg::WORD_W-1:0] w, input logic last,
                           input logic typed, input gcpp_pkg::kind_t kind,
                           input logic [gcpp_pkg::OPC_W-1:0] opc, input logic trunc);
        cmd_row_t row;
        row.word          = w;
        row.last          = last;
        row.typed         = typed;
        row.res           = '0;
        row.res.kind      = kind;
        row.res.word_out  = w;
        row.res.opcode    = opc;
        row.res.truncated = trunc;
        dir_rows.push_back(row);
    endtask

    task automatic push_word(input logic [gcpp_pkg::WORD_W-1:0] w, input logic last,
                             input logic typed, input gcpp_pkg::result_t fixed_res);
        gcpp_pkg::result_t r;
        while ($urandom_range(99) < tx_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= w;
        s_tlast  <= last;
        do @(posedge clk); while (!s_tready);
        r = decode_word(w, last);
        beats_due.push_back(typed ? fixed_res : r);
        words_sent++;
    endtask

    task automatic send_random_packet();
        logic [gcpp_pkg::WORD_W-1:0] hdr;
        logic [gcpp_pkg::ADDR_W-1:0] aim;
        int unsigned                 pick;
        int unsigned                 count;
        int unsigned                 n_words;
        int unsigned                 cut;
        logic                        broken;
        pick   = $urandom_range(99);
        hdr    = $urandom;
        count  = $urandom_range(5);
        aim    = ($urandom_range(1) == 0) ? ib_base_addr : ib_size_addr;
        broken = 1'b0;
        if (pick < 45)
        begin
            hdr[31:30] = gcpp_pkg::PKT_TYPE0;
            hdr[15]    = ($urandom_range(3) == 0);
            if ($urandom_range(1) == 0)
                hdr[12:0] = aim[14:2] - 13'($urandom_range(1));
        end
        else if (pick < 80)
            hdr[31:30] = gcpp_pkg::PKT_TYPE3;
        else if (pick < 88)
            hdr[31:30] = gcpp_pkg::PKT_TYPE2;
        else if (pick < 93)
            hdr[31:30] = PKT_TYPE1;
        else
        begin
            hdr[31:30] = ($urandom_range(1) == 0) ? gcpp_pkg::PKT_TYPE0 : gcpp_pkg::PKT_TYPE3;
            count      = hdr[29:16];
            broken     = 1'b1;
        end
        if (hdr[31:30] == gcpp_pkg::PKT_TYPE0 || hdr[31:30] == gcpp_pkg::PKT_TYPE3)
        begin
            hdr[29:16] = count[13:0];
            n_words    = count + 2;
        end
        else
            n_words = 1;
        if (broken)
            cut = $urandom_range((n_words - 2 < 3) ? n_words - 2 : 3);
        else
            cut = ($urandom_range(9) < 3) ? n_words - 1 : n_words;
        push_word(hdr, cut == 0, 1'b0, '0);
        for (int unsigned k = 1; k < n_words && k <= cut; k++)
            push_word($urandom, k == cut, 1'b0, '0);
    endtask

    task automatic set_ib_regs(input logic [gcpp_pkg::ADDR_W-1:0] base,
                               input logic [gcpp_pkg::ADDR_W-1:0] size);
        cfg_valid <= 1'b1;
        cfg_index <= gcpp_pkg::REG_IB_BASE;
        cfg_data  <= base;
        do @(posedge clk); while (!cfg_ready);
        cfg_index <= gcpp_pkg::REG_IB_SIZE;
        cfg_data  <= size;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid    <= 1'b0;
        ib_base_addr = base;
        ib_size_addr = size;
    endtask

    task automatic drain();
        while (beats_due.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_rx)
            begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_rx = 1'b0;
            end
            else
                m_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        gcpp_pkg::result_t got;
        gcpp_pkg::result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.kind       = gcpp_pkg::kind_t'(m_tuser[2:0]);
            got.ib_valid   = m_tuser[3];
            got.truncated  = m_tuser[4];
            got.reg_addr   = m_tdata[16:0];
            got.word_out   = m_tdata[48:17];
            got.opcode     = m_tdata[56:49];
            got.ib_address = m_tdata[88:57];
            got.ib_length  = m_tdata[120:89];
            if (beats_due.size() == 0)
            begin
                mismatches++;
                if (mismatches <= SHOW_LIMIT)
                    $display("unexpected beat: %s", show_beat(got));
            end
            else
            begin
                want = beats_due.pop_front();
                if (got !== want)
                begin
                    mismatches++;
                    if (mismatches <= SHOW_LIMIT)
                    begin
                        $display("mismatch expected %s", show_beat(want));
                        $display("         actual   %s", show_beat(got));
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        int unsigned target;
        add_row(32'h4000_0000, 1'b0, 1'b1, gcpp_pkg::KIND_BAD_TYPE,  8'h00, 1'b0);
        add_row(32'h7fff_ffff, 1'b1, 1'b1, gcpp_pkg::KIND_BAD_TYPE,  8'h00, 1'b0);
        add_row(32'h8000_0000, 1'b0, 1'b1, gcpp_pkg::KIND_TYPE2_HDR, 8'h00, 1'b0);
        add_row(32'hbfff_ffff, 1'b0, 1'b1, gcpp_pkg::KIND_TYPE2_HDR, 8'h00, 1'b0);
        add_row(32'h3fff_ffff, 1'b1, 1'b1, gcpp_pkg::KIND_TYPE0_HDR, 8'h00, 1'b1);
        add_row(32'hffff_ffff, 1'b1, 1'b1, gcpp_pkg::KIND_TYPE3_HDR, 8'hff, 1'b1);
        add_row(32'h0001_01c0, 1'b0, 1'b0, gcpp_pkg::KIND_TYPE0_HDR, 8'h00, 1'b0);
        add_row(32'hdead_beef, 1'b0, 1'b0, gcpp_pkg::KIND_REG_WRITE, 8'h00, 1'b0);
        add_row(32'h0000_0040, 1'b0, 1'b0, gcpp_pkg::KIND_REG_WRITE, 8'h00, 1'b0);
        add_row(32'hc000_1000, 1'b0, 1'b1, gcpp_pkg::KIND_TYPE3_HDR, 8'h10, 1'b0);
        add_row(32'hffff_ffff, 1'b1, 1'b0, gcpp_pkg::KIND_PAYLOAD,   8'h00, 1'b0);
        add_row(32'h0002_9fff, 1'b0, 1'b0, gcpp_pkg::KIND_TYPE0_HDR, 8'h00, 1'b0);
        add_row(32'h0000_0000, 1'b0, 1'b0, gcpp_pkg::KIND_REG_WRITE, 8'h00, 1'b0);
        add_row(32'hffff_ffff, 1'b0, 1'b0, gcpp_pkg::KIND_REG_WRITE, 8'h00, 1'b0);
        add_row(32'h1234_5678, 1'b0, 1'b0, gcpp_pkg::KIND_REG_WRITE, 8'h00, 1'b0);
        add_row(32'h0003_0010, 1'b0, 1'b0, gcpp_pkg::KIND_TYPE0_HDR, 8'h00, 1'b0);
        add_row(32'hcafe_f00d, 1'b1, 1'b0, gcpp_pkg::KIND_REG_WRITE, 8'h00, 1'b0);
        add_row(32'h8000_0000, 1'b1, 1'b1, gcpp_pkg::KIND_TYPE2_HDR, 8'h00, 1'b0);
        add_row(32'hc001_2300, 1'b0, 1'b0, gcpp_pkg::KIND_TYPE3_HDR, 8'h00, 1'b0);
        add_row(32'h5555_aaaa, 1'b0, 1'b0, gcpp_pkg::KIND_PAYLOAD,   8'h00, 1'b0);
        add_row(32'haaaa_5555, 1'b0, 1'b0, gcpp_pkg::KIND_PAYLOAD,   8'h00, 1'b0);
        add_row(32'h0000_01c0, 1'b0, 1'b0, gcpp_pkg::KIND_TYPE0_HDR, 8'h00, 1'b0);
        add_row(32'h0bad_f00d, 1'b0, 1'b0, gcpp_pkg::KIND_REG_WRITE, 8'h00, 1'b0);
        add_row(32'h0000_01c1, 1'b0, 1'b0, gcpp_pkg::KIND_TYPE0_HDR, 8'h00, 1'b0);
        add_row(32'h0000_0100, 1'b0, 1'b0, gcpp_pkg::KIND_REG_WRITE, 8'h00, 1'b0);

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        foreach (dir_rows[i])
            push_word(dir_rows[i].word, dir_rows[i].last, dir_rows[i].typed, dir_rows[i].res);

        for (int unsigned ph = 0; ph < NUM_PHASES; ph++)
        begin
            if (ph != 0)
            begin
                s_tvalid <= 1'b0;
                drain();
                set_ib_regs(BASE_PLAN[ph], SIZE_PLAN[ph]);
                tx_idle_pct = (ph < 2) ? 24 : (ph < 4) ? 72 : 0;
                rx_idle_pct = (ph < 2) ? 72 : (ph < 4) ? 24 : 0;
                if (ph == 4)
                    hold_rx = 1'b1;
            end
            target = words_sent + PHASE_WORDS;
            while (words_sent < target)
                send_random_packet();
        end

        s_tvalid <= 1'b0;
        drain();
        if (mismatches == 0 && beats_due.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
